// ===== hw/rtl/lnt_pkg.sv =====
package lnt_pkg;

   localparam int NUM_LETTERS = 48;

   localparam logic [5:0] CODE_EMPTY   = 6'd0;
   localparam logic [5:0] CODE_DZ      = 6'd9;
   localparam logic [5:0] CODE_DVZ     = 6'd10;
   localparam logic [5:0] CODE_CH      = 6'd16;
   localparam logic [5:0] CODE_CARON_Z = 6'd46;
   localparam logic [5:0] CODE_UNKNOWN = 6'd47;
   localparam logic [5:0] CODE_NONE    = 6'd0;

   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_ACUTE    = 3'd1;
   localparam logic [2:0] ERR_CARON    = 3'd2;
   localparam logic [2:0] ERR_DIGRAPH  = 3'd3;
   localparam logic [2:0] ERR_UMLAUT   = 3'd4;
   localparam logic [2:0] ERR_UNKNOWN  = 3'd5;

   localparam logic [1:0] CS_ASCII = 2'd0;
   localparam logic [1:0] CS_W1250 = 2'd1;
   localparam logic [1:0] CS_ISO   = 2'd2;
   localparam logic [1:0] CS_CP852 = 2'd3;

   localparam logic [7:0] CH_ACUTE    = 8'h2C;
   localparam logic [7:0] CH_CARON    = 8'h76;
   localparam logic [7:0] CH_UMLAUT   = 8'h3A;
   localparam logic [7:0] CH_BACKTICK = 8'h60;
   localparam logic [7:0] CH_EMPTY    = 8'h2E;
   localparam logic [7:0] CH_UNKNOWN  = 8'h3F;
   localparam logic [7:0] CH_A        = 8'h41;
   localparam logic [7:0] CH_C        = 8'h43;
   localparam logic [7:0] CH_D        = 8'h44;
   localparam logic [7:0] CH_H        = 8'h48;
   localparam logic [7:0] CH_Z        = 8'h5A;

   typedef struct packed {
      logic [5:0] code;
      logic [2:0] length;
      logic [2:0] err;
   } letter_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [7:0] base_of(input logic [5:0] code);
      logic [7:0] b;
      unique case (code)
         6'd1, 6'd2, 6'd3:    b = "A";
         6'd4:                b = "B";
         6'd5, 6'd6:          b = "C";
         6'd7, 6'd8:          b = "D";
         6'd11, 6'd12:        b = "E";
         6'd13:               b = "F";
         6'd14:               b = "G";
         6'd15:               b = "H";
         6'd17, 6'd18:        b = "I";
         6'd19:               b = "J";
         6'd20:               b = "K";
         6'd21, 6'd22, 6'd23: b = "L";
         6'd24:               b = "M";
         6'd25, 6'd26:        b = "N";
         6'd27, 6'd28, 6'd29: b = "O";
         6'd30:               b = "P";
         6'd31:               b = "Q";
         6'd32, 6'd33:        b = "R";
         6'd34, 6'd35:        b = "S";
         6'd36, 6'd37:        b = "T";
         6'd38, 6'd39:        b = "U";
         6'd40:               b = "V";
         6'd41:               b = "W";
         6'd42:               b = "X";
         6'd43, 6'd44:        b = "Y";
         6'd45, 6'd46:        b = "Z";
         default:             b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic [7:0] mark_of(input logic [5:0] code);
      logic [7:0] m;
      unique case (code)
         6'd2, 6'd12, 6'd18, 6'd22, 6'd28, 6'd33, 6'd39, 6'd44: m = CH_ACUTE;
         6'd3:                                                  m = CH_UMLAUT;
         6'd6, 6'd8, 6'd23, 6'd26, 6'd29, 6'd35, 6'd37, 6'd46:  m = CH_CARON;
         default:                                               m = 8'h00;
      endcase
      return m;
   endfunction

   // plain A-Z letter to code, CODE_NONE otherwise
   function automatic logic [5:0] plain_code(input logic [7:0] x);
      logic [5:0] c;
      unique case (x)
         "A": c = 6'd1;   "B": c = 6'd4;   "C": c = 6'd5;   "D": c = 6'd7;
         "E": c = 6'd11;  "F": c = 6'd13;  "G": c = 6'd14;  "H": c = 6'd15;
         "I": c = 6'd17;  "J": c = 6'd19;  "K": c = 6'd20;  "L": c = 6'd21;
         "M": c = 6'd24;  "N": c = 6'd25;  "O": c = 6'd27;  "P": c = 6'd30;
         "Q": c = 6'd31;  "R": c = 6'd32;  "S": c = 6'd34;  "T": c = 6'd36;
         "U": c = 6'd38;  "V": c = 6'd40;  "W": c = 6'd41;  "X": c = 6'd42;
         "Y": c = 6'd43;  "Z": c = 6'd45;
         default: c = CODE_NONE;
      endcase
      return c;
   endfunction

   function automatic logic [5:0] acute_code(input logic [7:0] x);
      logic [5:0] c;
      unique case (x)
         "A": c = 6'd2;   "E": c = 6'd12;  "I": c = 6'd18;  "L": c = 6'd22;
         "O": c = 6'd28;  "R": c = 6'd33;  "U": c = 6'd39;  "Y": c = 6'd44;
         default: c = CODE_NONE;
      endcase
      return c;
   endfunction

   function automatic logic [5:0] caron_code(input logic [7:0] x);
      logic [5:0] c;
      unique case (x)
         "C": c = 6'd6;   "D": c = 6'd8;   "L": c = 6'd23;  "N": c = 6'd26;
         "O": c = 6'd29;  "S": c = 6'd35;  "T": c = 6'd37;  "Z": c = 6'd46;
         default: c = CODE_NONE;
      endcase
      return c;
   endfunction

   function automatic logic [5:0] umlaut_code(input logic [7:0] x);
      return (x == CH_A) ? 6'd3 : CODE_NONE;
   endfunction

   // {windows-1250, iso-8859-2, cp852}
   function automatic logic [23:0] national_row(input logic [5:0] code);
      logic [23:0] r;
      unique case (code)
         6'd2:    r = 24'hC1_C1_B5;
         6'd3:    r = 24'hC4_C4_8E;
         6'd6:    r = 24'hC8_C8_AC;
         6'd8:    r = 24'hCF_CF_D2;
         6'd12:   r = 24'hC9_C9_90;
         6'd18:   r = 24'hCD_CD_D6;
         6'd22:   r = 24'hC5_C5_91;
         6'd23:   r = 24'hBC_A5_95;
         6'd26:   r = 24'hD2_D2_D5;
         6'd28:   r = 24'hD3_D3_E0;
         6'd29:   r = 24'hD4_D4_E2;
         6'd33:   r = 24'hC0_C0_E8;
         6'd35:   r = 24'h8A_A9_E6;
         6'd37:   r = 24'h8D_AB_9B;
         6'd39:   r = 24'hDA_DA_E9;
         6'd44:   r = 24'hDD_DD_ED;
         6'd46:   r = 24'h8E_AE_A6;
         default: r = 24'h00_00_00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] national_byte(input logic [5:0] code,
                                                input logic [1:0] cs);
      logic [23:0] r;
      logic [7:0]  b;
      r = national_row(code);
      unique case (cs)
         CS_W1250: b = r[23:16];
         CS_ISO:   b = r[15:8];
         CS_CP852: b = r[7:0];
         default:  b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// ===== hw/rtl/lnt_front.sv =====
module lnt_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  byte_accept,
   input  logic [7:0]            in_byte,
   output logic                  letter_valid,
   output lnt_pkg::letter_type   letter
);

   localparam logic [2:0] PH_IDLE     = 3'd0;
   localparam logic [2:0] PH_ACUTE    = 3'd1;
   localparam logic [2:0] PH_CARON    = 3'd2;
   localparam logic [2:0] PH_UMLAUT   = 3'd3;
   localparam logic [2:0] PH_TICK     = 3'd4;
   localparam logic [2:0] PH_TICK_C   = 3'd5;
   localparam logic [2:0] PH_TICK_D   = 3'd6;
   localparam logic [2:0] PH_TICK_DV  = 3'd7;

   logic [2:0] phase_ff, phase_in, phase_next;
   logic       done;
   logic [5:0] code, found;
   logic [2:0] length, err;

   always_comb begin
      phase_next = phase_ff;
      done       = 1'b0;
      code       = lnt_pkg::CODE_EMPTY;
      length     = 3'd1;
      err        = lnt_pkg::ERR_NONE;
      found      = lnt_pkg::CODE_NONE;
      unique case (phase_ff)
         PH_IDLE: begin
            priority if (in_byte == lnt_pkg::CH_EMPTY) begin
               done = 1'b1;
               code = lnt_pkg::CODE_EMPTY;
            end else if (in_byte == lnt_pkg::CH_UNKNOWN) begin
               done = 1'b1;
               code = lnt_pkg::CODE_UNKNOWN;
            end else if (in_byte == lnt_pkg::CH_ACUTE) begin
               phase_next = PH_ACUTE;
            end else if (in_byte == lnt_pkg::CH_CARON) begin
               phase_next = PH_CARON;
            end else if (in_byte == lnt_pkg::CH_UMLAUT) begin
               phase_next = PH_UMLAUT;
            end else if (in_byte == lnt_pkg::CH_BACKTICK) begin
               phase_next = PH_TICK;
            end else begin
               done  = 1'b1;
               found = lnt_pkg::plain_code(in_byte);
               code  = found;
               err   = (found == lnt_pkg::CODE_NONE) ? lnt_pkg::ERR_UNKNOWN
                                                     : lnt_pkg::ERR_NONE;
            end
         end
         PH_ACUTE, PH_CARON, PH_UMLAUT: begin
            done   = 1'b1;
            length = 3'd2;
            unique case (phase_ff)
               PH_ACUTE:  found = lnt_pkg::acute_code(in_byte);
               PH_CARON:  found = lnt_pkg::caron_code(in_byte);
               default:   found = lnt_pkg::umlaut_code(in_byte);
            endcase
            code = found;
            if (found == lnt_pkg::CODE_NONE) begin
               unique case (phase_ff)
                  PH_ACUTE:  err = lnt_pkg::ERR_ACUTE;
                  PH_CARON:  err = lnt_pkg::ERR_CARON;
                  default:   err = lnt_pkg::ERR_UMLAUT;
               endcase
            end
         end
         PH_TICK: begin
            priority if (in_byte == lnt_pkg::CH_C) begin
               phase_next = PH_TICK_C;
            end else if (in_byte == lnt_pkg::CH_D) begin
               phase_next = PH_TICK_D;
            end else begin
               done   = 1'b1;
               length = 3'd2;
               err    = lnt_pkg::ERR_DIGRAPH;
            end
         end
         PH_TICK_C: begin
            done   = 1'b1;
            length = 3'd3;
            if (in_byte == lnt_pkg::CH_H) begin
               code = lnt_pkg::CODE_CH;
            end else begin
               err = lnt_pkg::ERR_DIGRAPH;
            end
         end
         PH_TICK_D: begin
            priority if (in_byte == lnt_pkg::CH_Z) begin
               done   = 1'b1;
               length = 3'd3;
               code   = lnt_pkg::CODE_DZ;
            end else if (in_byte == lnt_pkg::CH_CARON) begin
               phase_next = PH_TICK_DV;
            end else begin
               done   = 1'b1;
               length = 3'd3;
               err    = lnt_pkg::ERR_DIGRAPH;
            end
         end
         default: begin
            done   = 1'b1;
            length = 3'd4;
            if (in_byte == lnt_pkg::CH_Z) begin
               code = lnt_pkg::CODE_DVZ;
            end else begin
               err = lnt_pkg::ERR_DIGRAPH;
            end
         end
      endcase
      if (done) begin
         phase_next = PH_IDLE;
      end
      if (err != lnt_pkg::ERR_NONE) begin
         code = lnt_pkg::CODE_EMPTY;
      end
   end

   assign phase_in = byte_accept ? phase_next : phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   assign letter_valid  = byte_accept & done;
   assign letter.code   = code;
   assign letter.length = length;
   assign letter.err    = err;

endmodule

// ===== hw/rtl/lnt_queue.sv =====
module lnt_queue #(
   parameter int DEPTH = 2
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  lnt_pkg::letter_type         wr_data,
   input  logic                        rd_en,
   output lnt_pkg::letter_type         rd_data,
   output lnt_pkg::queue_status_type   status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   lnt_pkg::letter_type mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_wr, do_rd;

   assign do_wr = wr_en & (count_ff != CNT_FULL);
   assign do_rd = rd_en & (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_wr, do_rd})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data      = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_FULL);
   assign status.empty = (count_ff == '0);

endmodule

// ===== hw/rtl/lnt_back.sv =====
module lnt_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [1:0]                  charset,
   input  lnt_pkg::letter_type         letter,
   input  lnt_pkg::queue_status_type   q_status,
   output logic                        q_pop,
   input  logic                        pop,
   output logic                        empty,
   output logic [5:0]                  letter_code,
   output logic [2:0]                  notation_length,
   output logic [2:0]                  out_count,
   output logic [7:0]                  out_byte0,
   output logic [7:0]                  out_byte1,
   output logic [7:0]                  out_byte2,
   output logic [7:0]                  out_byte3,
   output logic [2:0]                  error_kind
);

   logic       valid_ff, valid_in, load;
   logic [5:0] code_ff, code_in;
   logic [2:0] len_ff, count_ff, count_in, err_ff;
   logic [7:0] b0_ff, b1_ff, b2_ff, b3_ff;
   logic [7:0] b0_in, b1_in, b2_in, b3_in;
   logic [7:0] base, mark;
   logic       is_ch;

   assign load     = ~q_status.empty & (~valid_ff | pop);
   assign valid_in = load | (valid_ff & ~pop);
   assign q_pop    = load;

   always_comb begin
      code_in  = letter.code;
      count_in = 3'd0;
      b0_in    = 8'h00;
      b1_in    = 8'h00;
      b2_in    = 8'h00;
      b3_in    = 8'h00;
      base     = lnt_pkg::base_of(letter.code);
      mark     = lnt_pkg::mark_of(letter.code);
      is_ch    = (letter.code == lnt_pkg::CODE_CH);
      priority if (letter.err != lnt_pkg::ERR_NONE ||
                   letter.code > 6'(lnt_pkg::NUM_LETTERS - 1)) begin
         code_in = lnt_pkg::CODE_EMPTY;
      end else if (letter.code == lnt_pkg::CODE_EMPTY) begin
         count_in = 3'd0;
      end else if (letter.code == lnt_pkg::CODE_UNKNOWN) begin
         b0_in    = lnt_pkg::CH_UNKNOWN;
         count_in = 3'd1;
      end else if (is_ch || letter.code == lnt_pkg::CODE_DZ) begin
         if (charset == lnt_pkg::CS_ASCII) begin
            b0_in    = lnt_pkg::CH_BACKTICK;
            b1_in    = is_ch ? lnt_pkg::CH_C : lnt_pkg::CH_D;
            b2_in    = is_ch ? lnt_pkg::CH_H : lnt_pkg::CH_Z;
            count_in = 3'd3;
         end else begin
            b0_in    = is_ch ? lnt_pkg::CH_C : lnt_pkg::CH_D;
            b1_in    = is_ch ? lnt_pkg::CH_H : lnt_pkg::CH_Z;
            count_in = 3'd2;
         end
      end else if (letter.code == lnt_pkg::CODE_DVZ) begin
         if (charset == lnt_pkg::CS_ASCII) begin
            b0_in    = lnt_pkg::CH_BACKTICK;
            b1_in    = lnt_pkg::CH_D;
            b2_in    = lnt_pkg::CH_CARON;
            b3_in    = lnt_pkg::CH_Z;
            count_in = 3'd4;
         end else begin
            b0_in    = lnt_pkg::CH_D;
            b1_in    = lnt_pkg::national_byte(lnt_pkg::CODE_CARON_Z, charset);
            count_in = 3'd2;
         end
      end else if (mark == 8'h00) begin
         b0_in    = base;
         count_in = 3'd1;
      end else if (charset == lnt_pkg::CS_ASCII) begin
         b0_in    = mark;
         b1_in    = base;
         count_in = 3'd2;
      end else begin
         b0_in    = lnt_pkg::national_byte(letter.code, charset);
         count_in = 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         code_ff  <= code_in;
         len_ff   <= letter.length;
         count_ff <= count_in;
         err_ff   <= letter.err;
         b0_ff    <= b0_in;
         b1_ff    <= b1_in;
         b2_ff    <= b2_in;
         b3_ff    <= b3_in;
      end
   end

   assign empty           = ~valid_ff;
   assign letter_code     = code_ff;
   assign notation_length = len_ff;
   assign out_count       = count_ff;
   assign out_byte0       = b0_ff;
   assign out_byte1       = b1_ff;
   assign out_byte2       = b2_ff;
   assign out_byte3       = b3_ff;
   assign error_kind      = err_ff;

endmodule

// ===== hw/rtl/letter_notation_transcoder_core.sv =====
// Letter notation transcoder: takes one notation byte per cycle on push/full and
// delivers one transfer per completed letter on empty/pop, with its internal code,
// the notation length, the error kind and up to four bytes in the charset chosen by
// csr_write_data. Prefix bytes produce no transfer. A letter's result passes through
// the letter queue behind the parser and then the output register of the encoder
// before it is visible. Input and output each move one byte or letter per cycle,
// unless full or a withheld pop holds them; full rises only once the
// QUEUE_DEPTH-entry letter queue and the output register are all occupied. Change
// the charset only while no result is outstanding.
module letter_notation_transcoder_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_in_byte,
   output logic       empty,
   input  logic       pop,
   output logic [5:0] rsp_letter_code,
   output logic [2:0] rsp_notation_length,
   output logic [2:0] rsp_out_count,
   output logic [7:0] rsp_out_byte0,
   output logic [7:0] rsp_out_byte1,
   output logic [7:0] rsp_out_byte2,
   output logic [7:0] rsp_out_byte3,
   output logic [2:0] rsp_error_kind,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_write_data
);

   logic [1:0]                  cs_ff, cs_in;
   logic                        byte_accept, letter_valid, q_pop;
   lnt_pkg::letter_type         front_letter, head_letter;
   lnt_pkg::queue_status_type   q_status;

   assign cs_in = csr_write_enable ? csr_write_data : cs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cs_ff <= lnt_pkg::CS_ASCII;
      end else begin
         cs_ff <= cs_in;
      end
   end

   assign full        = q_status.full;
   assign byte_accept = push & ~q_status.full;

   lnt_front u_front (
      .clock        (clock),
      .reset        (reset),
      .byte_accept  (byte_accept),
      .in_byte      (req_in_byte),
      .letter_valid (letter_valid),
      .letter       (front_letter)
   );

   lnt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (letter_valid),
      .wr_data (front_letter),
      .rd_en   (q_pop),
      .rd_data (head_letter),
      .status  (q_status)
   );

   lnt_back u_back (
      .clock           (clock),
      .reset           (reset),
      .charset         (cs_ff),
      .letter          (head_letter),
      .q_status        (q_status),
      .q_pop           (q_pop),
      .pop             (pop),
      .empty           (empty),
      .letter_code     (rsp_letter_code),
      .notation_length (rsp_notation_length),
      .out_count       (rsp_out_count),
      .out_byte0       (rsp_out_byte0),
      .out_byte1       (rsp_out_byte1),
      .out_byte2       (rsp_out_byte2),
      .out_byte3       (rsp_out_byte3),
      .error_kind      (rsp_error_kind)
   );

   a_reset_clears : assert property (@(posedge clock)
      reset |=> empty && !full)
      else $error("result or queue not cleared by reset");

   a_result_held : assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_letter_code) && $stable(rsp_out_count))
      else $error("waiting result lost or changed");

   a_error_no_bytes : assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_error_kind != lnt_pkg::ERR_NONE |->
         rsp_letter_code == lnt_pkg::CODE_EMPTY && rsp_out_count == 3'd0)
      else $error("error result carries a letter");

   a_full_no_write : assert property (@(posedge clock) disable iff (reset)
      q_status.full && !q_pop |=> !q_status.empty)
      else $error("letter queue drained without a read");

endmodule

// ===== sim/letter_notation_transcoder_core_test.sv =====
module letter_notation_transcoder_core_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_BYTES = 140;
   localparam int LONG_HOLD = 64;

   typedef enum logic [2:0] {
      PH_IDLE, PH_ACUTE, PH_CARON, PH_UMLAUT, PH_TICK, PH_TICK_C, PH_TICK_D, PH_TICK_DV
   } parse_phase_type;

   typedef struct {
      logic [5:0] code;
      logic [2:0] length;
      logic [2:0] count;
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      logic [7:0] b3;
      logic [2:0] err;
   } letter_result_type;

   class transcode_board;
      // per-code base letter ('-' none) and notation mark (' ' none)
      string base_map = {"-AAABCCDD--E", "EFGH-IIJKLLL", "MNNOOOPQRRSS", "TTUUVWXYYZZ-"};
      string mark_map = {"  ,:  v v   ", ",     ,   ,v", "  v ,v   , v", " v ,    , v "};
      parse_phase_type phase = PH_IDLE;
      logic [1:0] charset = lnt_pkg::CS_ASCII;
      letter_result_type expected_letters[$];
      int errors = 0;

      function logic [7:0] base_at(int code);
         return (base_map[code] == "-") ? 8'h00 : base_map[code];
      endfunction

      function logic [7:0] mark_at(int code);
         return (mark_map[code] == " ") ? 8'h00 : mark_map[code];
      endfunction

      function logic [7:0] charset_byte(int code, logic [1:0] cs);
         logic [23:0] row;
         case (code)
            2:  row = 24'hC1_C1_B5;
            3:  row = 24'hC4_C4_8E;
            6:  row = 24'hC8_C8_AC;
            8:  row = 24'hCF_CF_D2;
            12: row = 24'hC9_C9_90;
            18: row = 24'hCD_CD_D6;
            22: row = 24'hC5_C5_91;
            23: row = 24'hBC_A5_95;
            26: row = 24'hD2_D2_D5;
            28: row = 24'hD3_D3_E0;
            29: row = 24'hD4_D4_E2;
            33: row = 24'hC0_C0_E8;
            35: row = 24'h8A_A9_E6;
            37: row = 24'h8D_AB_9B;
            39: row = 24'hDA_DA_E9;
            44: row = 24'hDD_DD_ED;
            46: row = 24'h8E_AE_A6;
            default: row = 24'h0;
         endcase
         case (cs)
            lnt_pkg::CS_W1250: return row[23:16];
            lnt_pkg::CS_ISO:   return row[15:8];
            lnt_pkg::CS_CP852: return row[7:0];
            default:           return 8'h00;
         endcase
      endfunction

      function int find_letter(logic [7:0] mark, logic [7:0] letter);
         if (letter == 8'h00) return -1;
         for (int i = 0; i < lnt_pkg::NUM_LETTERS; i++)
            if (base_at(i) == letter && mark_at(i) == mark) return i;
         return -1;
      endfunction

      function void emit(int code, int len, logic [2:0] err);
         letter_result_type r;
         logic [7:0] b[4];
         int n;
         b = '{default: 8'h00};
         n = 0;
         if (err != lnt_pkg::ERR_NONE) begin
            code = 0;
         end else if (code == lnt_pkg::CODE_EMPTY) begin
            n = 0;
         end else if (code == lnt_pkg::CODE_UNKNOWN) begin
            b[0] = lnt_pkg::CH_UNKNOWN;
            n = 1;
         end else if (code == lnt_pkg::CODE_CH || code == lnt_pkg::CODE_DZ) begin
            if (charset == lnt_pkg::CS_ASCII) b[n++] = lnt_pkg::CH_BACKTICK;
            b[n++] = (code == lnt_pkg::CODE_CH) ? lnt_pkg::CH_C : lnt_pkg::CH_D;
            b[n++] = (code == lnt_pkg::CODE_CH) ? lnt_pkg::CH_H : lnt_pkg::CH_Z;
         end else if (code == lnt_pkg::CODE_DVZ) begin
            if (charset == lnt_pkg::CS_ASCII) begin
               b = '{lnt_pkg::CH_BACKTICK, lnt_pkg::CH_D, lnt_pkg::CH_CARON, lnt_pkg::CH_Z};
               n = 4;
            end else begin
               b[0] = lnt_pkg::CH_D;
               b[1] = charset_byte(lnt_pkg::CODE_CARON_Z, charset);
               n = 2;
            end
         end else if (mark_at(code) == 8'h00) begin
            b[0] = base_at(code);
            n = 1;
         end else if (charset == lnt_pkg::CS_ASCII) begin
            b[0] = mark_at(code);
            b[1] = base_at(code);
            n = 2;
         end else begin
            b[0] = charset_byte(code, charset);
            n = 1;
         end
         r.code = code[5:0];
         r.length = len[2:0];
         r.count = n[2:0];
         r.b0 = b[0];
         r.b1 = b[1];
         r.b2 = b[2];
         r.b3 = b[3];
         r.err = err;
         expected_letters.push_back(r);
         phase = PH_IDLE;
      endfunction

      function void marked(logic [7:0] mark, logic [7:0] x, logic [2:0] err);
         int c;
         c = find_letter(mark, x);
         if (c < 0) emit(0, 2, err);
         else emit(c, 2, lnt_pkg::ERR_NONE);
      endfunction

      function void note_byte(logic [7:0] x);
         case (phase)
            PH_IDLE: begin
               if (x == lnt_pkg::CH_EMPTY) emit(lnt_pkg::CODE_EMPTY, 1, lnt_pkg::ERR_NONE);
               else if (x == lnt_pkg::CH_UNKNOWN)
                  emit(lnt_pkg::CODE_UNKNOWN, 1, lnt_pkg::ERR_NONE);
               else if (x == lnt_pkg::CH_ACUTE) phase = PH_ACUTE;
               else if (x == lnt_pkg::CH_CARON) phase = PH_CARON;
               else if (x == lnt_pkg::CH_UMLAUT) phase = PH_UMLAUT;
               else if (x == lnt_pkg::CH_BACKTICK) phase = PH_TICK;
               else if (x >= lnt_pkg::CH_A && x <= lnt_pkg::CH_Z)
                  emit(find_letter(8'h00, x), 1, lnt_pkg::ERR_NONE);
               else emit(0, 1, lnt_pkg::ERR_UNKNOWN);
            end
            PH_ACUTE:  marked(lnt_pkg::CH_ACUTE, x, lnt_pkg::ERR_ACUTE);
            PH_CARON:  marked(lnt_pkg::CH_CARON, x, lnt_pkg::ERR_CARON);
            PH_UMLAUT: marked(lnt_pkg::CH_UMLAUT, x, lnt_pkg::ERR_UMLAUT);
            PH_TICK: begin
               if (x == lnt_pkg::CH_C) phase = PH_TICK_C;
               else if (x == lnt_pkg::CH_D) phase = PH_TICK_D;
               else emit(0, 2, lnt_pkg::ERR_DIGRAPH);
            end
            PH_TICK_C: begin
               if (x == lnt_pkg::CH_H) emit(lnt_pkg::CODE_CH, 3, lnt_pkg::ERR_NONE);
               else emit(0, 3, lnt_pkg::ERR_DIGRAPH);
            end
            PH_TICK_D: begin
               if (x == lnt_pkg::CH_Z) emit(lnt_pkg::CODE_DZ, 3, lnt_pkg::ERR_NONE);
               else if (x == lnt_pkg::CH_CARON) phase = PH_TICK_DV;
               else emit(0, 3, lnt_pkg::ERR_DIGRAPH);
            end
            default: begin
               if (x == lnt_pkg::CH_Z) emit(lnt_pkg::CODE_DVZ, 4, lnt_pkg::ERR_NONE);
               else emit(0, 4, lnt_pkg::ERR_DIGRAPH);
            end
         endcase
      endfunction

      function void check_field(string name, int unsigned exp, int unsigned act);
         if (exp != act) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp, act);
            errors++;
         end
      endfunction

      function void check_letter(letter_result_type got);
         letter_result_type exp;
         if (expected_letters.size() == 0) begin
            $error("unexpected transfer: letter_code %0d", got.code);
            errors++;
            return;
         end
         exp = expected_letters.pop_front();
         check_field("letter_code", exp.code, got.code);
         check_field("notation_length", exp.length, got.length);
         check_field("out_count", exp.count, got.count);
         check_field("out_byte0", exp.b0, got.b0);
         check_field("out_byte1", exp.b1, got.b1);
         check_field("out_byte2", exp.b2, got.b2);
         check_field("out_byte3", exp.b3, got.b3);
         check_field("error_kind", exp.err, got.err);
      endfunction

      function int pending();
         return expected_letters.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       push = 1'b0;
   logic [7:0] req_in_byte = 8'h00;
   logic       pop = 1'b0;
   logic       csr_write_enable = 1'b0;
   logic [1:0] csr_write_data = 2'd0;
   logic       full;
   logic       empty;
   logic [5:0] rsp_letter_code;
   logic [2:0] rsp_notation_length;
   logic [2:0] rsp_out_count;
   logic [7:0] rsp_out_byte0;
   logic [7:0] rsp_out_byte1;
   logic [7:0] rsp_out_byte2;
   logic [7:0] rsp_out_byte3;
   logic [2:0] rsp_error_kind;

   transcode_board board = new();
   bit quiet = 1'b0;
   bit hold_request = 1'b0;
   int cycles = 0;

   letter_notation_transcoder_core dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_in_byte(req_in_byte),
      .empty(empty),
      .pop(pop),
      .rsp_letter_code(rsp_letter_code),
      .rsp_notation_length(rsp_notation_length),
      .rsp_out_count(rsp_out_count),
      .rsp_out_byte0(rsp_out_byte0),
      .rsp_out_byte1(rsp_out_byte1),
      .rsp_out_byte2(rsp_out_byte2),
      .rsp_out_byte3(rsp_out_byte3),
      .rsp_error_kind(rsp_error_kind),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // result side: random stall bursts plus one long hold-off
   initial begin
      letter_result_type got;
      int stall_left;
      int hold_left;
      bit hold_done;
      stall_left = 0;
      hold_left = 0;
      hold_done = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (pop && !empty) begin
            got.code = rsp_letter_code;
            got.length = rsp_notation_length;
            got.count = rsp_out_count;
            got.b0 = rsp_out_byte0;
            got.b1 = rsp_out_byte1;
            got.b2 = rsp_out_byte2;
            got.b3 = rsp_out_byte3;
            got.err = rsp_error_kind;
            board.check_letter(got);
         end
         if (hold_request && !hold_done) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            pop <= 1'b0;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 3);
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   task automatic send_byte(logic [7:0] b);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      push <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (full);
      board.note_byte(b);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic send_letter(int code);
      logic [7:0] mark;
      mark = board.mark_at(code);
      if (code == lnt_pkg::CODE_EMPTY) send_byte(lnt_pkg::CH_EMPTY);
      else if (code == lnt_pkg::CODE_UNKNOWN) send_byte(lnt_pkg::CH_UNKNOWN);
      else if (code == lnt_pkg::CODE_CH) send_text("`CH");
      else if (code == lnt_pkg::CODE_DZ) send_text("`DZ");
      else if (code == lnt_pkg::CODE_DVZ) send_text("`DvZ");
      else begin
         if (mark != 8'h00) send_byte(mark);
         send_byte(board.base_at(code));
      end
   endtask

   task automatic send_broken();
      case ($urandom_range(0, 6))
         0: send_byte(lnt_pkg::CH_ACUTE);
         1: send_byte(lnt_pkg::CH_CARON);
         2: send_byte(lnt_pkg::CH_UMLAUT);
         3: send_byte(lnt_pkg::CH_BACKTICK);
         4: send_text("`C");
         5: send_text("`D");
         default: send_text("`Dv");
      endcase
      send_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic drain();
      push <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_charset(logic [1:0] cs);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data <= cs;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.charset = cs;
   endtask

   task automatic random_phase(int n_bytes);
      int r;
      r = 0;
      for (int sent = 0; sent < n_bytes; sent++) begin
         r = $urandom_range(0, 99);
         if (r < 65) begin
            send_letter($urandom_range(0, lnt_pkg::NUM_LETTERS - 1));
         end else if (r < 85) begin
            send_broken();
            sent++;
         end else begin
            send_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin
      logic [1:0] plan[4];
      plan = '{lnt_pkg::CS_CP852, lnt_pkg::CS_W1250, lnt_pkg::CS_ISO, lnt_pkg::CS_ASCII};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset charset: plain letters, specials, each prefix good and bad, digraphs
      send_text("AZ.?,A,BvZvA:A:E`CH`CX`DZ`DvZ`DvX`DX`Xa");
      send_byte(8'h00);
      send_byte(8'hFF);

      foreach (plan[i]) begin
         write_charset(plan[i]);
         if (plan[i] == lnt_pkg::CS_ISO) hold_request = 1'b1;
         if (i == 3) quiet = 1'b1;
         random_phase(PHASE_BYTES);
      end

      drain();
      if (board.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
